FILE: rtl/tga_rle_pixel_encoder_unit_defines.svh
// Assertion macros used by the checker file of the TGA RLE pixel encoder.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TGA_RLE_PIXEL_ENCODER_UNIT_DEFINES_SVH
`define TGA_RLE_PIXEL_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define TGA_RLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define TGA_RLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tga_rle_pkg.sv
// Shared constants, command opcodes and the command record of the TGA RLE encoder.
// No dependencies; all files but tga_rle_ram and the defines header import this package.
package tga_rle_pkg;

  localparam int PIXEL_W    = 32;
  localparam int HDR_W      = 8;
  localparam int MAX_PACKET = 60;
  localparam int RAW_LIMIT  = 58;
  localparam int RAW_CAP    = (MAX_PACKET < RAW_LIMIT) ? MAX_PACKET : RAW_LIMIT;
  localparam int RUN_CAP    = (MAX_PACKET > 127) ? 127 : MAX_PACKET;
  localparam int RUN_MIN    = 4;
  localparam int CNT_W      = 7;
  localparam int TAIL_W     = $clog2(RUN_MIN);
  localparam int RAW_CNT_W  = $clog2(RAW_CAP + 1);
  localparam int RAW_AW     = $clog2(RAW_CAP);
  localparam int CMD_DEPTH  = 4;
  localparam int CMD_AW     = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

  localparam logic [HDR_W-1:0] RUN_FLAG = 8'h80;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_RUN,
    OP_RAW
  } cmd_op_t;

  // One unit of work for the emitter. For OP_RAW, cnt copies of value are
  // appended to the raw store, then the open raw packet is flushed if flush.
  typedef struct packed {
    cmd_op_t            op;
    logic [PIXEL_W-1:0] value;
    logic [CNT_W-1:0]   cnt;
    logic               flush;
    logic               last;
    logic               img_end;
  } cmd_t;

endpackage

FILE: rtl/tga_rle_if.sv
// Valid/ready channel interfaces for the pixel input and the packet word output.
// Depends on tga_rle_pkg for the field widths.
interface tga_rle_pix_if;
  import tga_rle_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_value;
  logic               image_end;

  modport source (output valid, pixel_value, image_end, input ready);
  modport sink (input valid, pixel_value, image_end, output ready);
endinterface

interface tga_rle_word_if;
  import tga_rle_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] out_word;
  logic               is_header;
  logic               burst_last;
  logic               stream_end;

  modport source (output valid, out_word, is_header, burst_last, stream_end, input ready);
  modport sink (input valid, out_word, is_header, burst_last, stream_end, output ready);
endinterface

FILE: rtl/tga_rle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tga_rle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/tga_rle_cmd_fifo.sv
// Short command queue between the classifier and the packet emitter.
// Depends on tga_rle_pkg for the command record and the queue depth.
module tga_rle_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tga_rle_pkg::cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output tga_rle_pkg::cmd_t pop_cmd,
  output logic              empty
);
  import tga_rle_pkg::*;

  cmd_t                 entry_r [CMD_DEPTH];
  logic [CMD_AW-1:0]    wr_ptr_r;
  logic [CMD_AW-1:0]    rd_ptr_r;
  logic [CMD_CNT_W-1:0] count_r;

  assign full    = (count_r == CMD_CNT_W'(CMD_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + CMD_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + CMD_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CMD_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CMD_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/tga_rle_front.sv
// Input side of the encoder: accepts pixels, tracks the trailing group of equal
// pixels and turns each pixel into zero to two emitter commands. Uses tga_rle_pkg.
module tga_rle_front (
  input  logic              clk,
  input  logic              rst_n,
  tga_rle_pix_if.sink       in_chan,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  output logic              push,
  output tga_rle_pkg::cmd_t push_cmd,
  input  logic              q_full
);
  import tga_rle_pkg::*;

  logic               comp_en_r;
  logic [PIXEL_W-1:0] run_value_r, run_value_nxt;
  logic [CNT_W-1:0]   run_count_r, run_count_nxt;
  logic               in_run_r, in_run_nxt;
  logic               pend_valid_r;
  cmd_t               pend_cmd_r;

  logic               accept;
  logic [PIXEL_W-1:0] px;
  logic               end_i;
  logic [CNT_W-1:0]   rc_inc;
  cmd_t               c1, c2;
  logic               v1, v2;

  function automatic cmd_t make_cmd(input cmd_op_t op, input logic [PIXEL_W-1:0] value,
                                    input logic [CNT_W-1:0] cnt, input logic flush,
                                    input logic last, input logic img_end);
    cmd_t c;
    c.op      = op;
    c.value   = value;
    c.cnt     = cnt;
    c.flush   = flush;
    c.last    = last;
    c.img_end = img_end;
    return c;
  endfunction

  assign in_chan.ready = !pend_valid_r && !q_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign px            = in_chan.pixel_value;
  assign end_i         = in_chan.image_end;
  assign rc_inc        = run_count_r + CNT_W'(1);

  always_comb begin
    c1            = make_cmd(OP_PASS, px, '0, 1'b0, 1'b1, end_i);
    c2            = make_cmd(OP_PASS, px, '0, 1'b0, 1'b1, end_i);
    v1            = 1'b0;
    v2            = 1'b0;
    run_value_nxt = run_value_r;
    run_count_nxt = run_count_r;
    in_run_nxt    = in_run_r;
    if (!comp_en_r) begin
      v1 = 1'b1;
    end else begin
      if (in_run_r) begin
        if (px == run_value_r && run_count_r < CNT_W'(RUN_CAP)) begin
          run_count_nxt = rc_inc;
          if (end_i) begin
            c1 = make_cmd(OP_RUN, run_value_r, rc_inc, 1'b0, 1'b1, 1'b1);
            v1 = 1'b1;
          end
        end else begin
          // The run breaks or is full: close it and start a new group.
          c1 = make_cmd(OP_RUN, run_value_r, run_count_r, 1'b0, !end_i, 1'b0);
          v1 = 1'b1;
          run_value_nxt = px;
          run_count_nxt = CNT_W'(1);
          in_run_nxt    = 1'b0;
          if (end_i) begin
            c2 = make_cmd(OP_RAW, px, CNT_W'(1), 1'b1, 1'b1, 1'b1);
            v2 = 1'b1;
          end
        end
      end else if (run_count_r != '0 && px == run_value_r) begin
        run_count_nxt = rc_inc;
        if (rc_inc >= CNT_W'(RUN_MIN)) begin
          // The group becomes a run: the raw packet before it closes now.
          c1 = make_cmd(OP_RAW, px, '0, 1'b1, !end_i, 1'b0);
          v1 = 1'b1;
          in_run_nxt = 1'b1;
          if (end_i) begin
            c2 = make_cmd(OP_RUN, px, rc_inc, 1'b0, 1'b1, 1'b1);
            v2 = 1'b1;
          end
        end else if (end_i) begin
          c1 = make_cmd(OP_RAW, px, rc_inc, 1'b1, 1'b1, 1'b1);
          v1 = 1'b1;
        end
      end else begin
        if (run_count_r != '0) begin
          c1 = make_cmd(OP_RAW, run_value_r, run_count_r, 1'b0, !end_i, 1'b0);
          v1 = 1'b1;
        end
        run_value_nxt = px;
        run_count_nxt = CNT_W'(1);
        if (end_i) begin
          if (run_count_r != '0) begin
            c2 = make_cmd(OP_RAW, px, CNT_W'(1), 1'b1, 1'b1, 1'b1);
            v2 = 1'b1;
          end else begin
            c1 = make_cmd(OP_RAW, px, CNT_W'(1), 1'b1, 1'b1, 1'b1);
            v1 = 1'b1;
          end
        end
      end
      if (end_i) begin
        run_value_nxt = '0;
        run_count_nxt = '0;
        in_run_nxt    = 1'b0;
      end
    end
  end

  assign push     = pend_valid_r ? !q_full : (accept && v1);
  assign push_cmd = pend_valid_r ? pend_cmd_r : c1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_en_r    <= 1'b1;
      run_value_r  <= '0;
      run_count_r  <= '0;
      in_run_r     <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (cfg_we) begin
      comp_en_r    <= cfg_wdata;
      run_value_r  <= '0;
      run_count_r  <= '0;
      in_run_r     <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (pend_valid_r && !q_full) begin
        pend_valid_r <= 1'b0;
      end
      if (accept) begin
        run_value_r  <= run_value_nxt;
        run_count_r  <= run_count_nxt;
        in_run_r     <= in_run_nxt;
        pend_valid_r <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && v2) begin
      pend_cmd_r <= c2;
    end
  end

endmodule

FILE: rtl/tga_rle_back.sv
// Output side of the encoder: executes queued commands, owns the raw pixel store
// and the output register. Uses tga_rle_pkg, tga_rle_ram and tga_rle_word_if.
module tga_rle_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              q_empty,
  input  tga_rle_pkg::cmd_t q_cmd,
  output logic              pop,
  tga_rle_word_if.source    out_chan
);
  import tga_rle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_RUN_HDR,
    S_RUN_PIX,
    S_PUSH,
    S_FL_HDR,
    S_FL_PIX
  } state_t;

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [TAIL_W-1:0]    rem_r, rem_nxt;
  logic [RAW_CNT_W-1:0] raw_count_r, raw_count_nxt;
  logic [RAW_AW-1:0]    rd_idx_r, rd_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [PIXEL_W-1:0]   out_word_r, out_word_nxt;
  logic                 out_hdr_r, out_hdr_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_end_r, out_end_nxt;

  logic                 free;
  logic                 emit;
  logic [PIXEL_W-1:0]   em_word;
  logic                 em_hdr;
  logic                 em_final;
  logic                 wr_en;
  logic                 last_pix;
  logic [RAW_CNT_W-1:0] raw_inc;
  logic [RAW_CNT_W-1:0] raw_dec;
  logic [HDR_W-1:0]     run_hdr;
  logic [PIXEL_W-1:0]   rd_data;

  assign free     = !out_valid_r || out_chan.ready;
  assign raw_inc  = raw_count_r + RAW_CNT_W'(1);
  assign raw_dec  = raw_count_r - RAW_CNT_W'(1);
  assign run_hdr  = RUN_FLAG | HDR_W'(cmd_r.cnt - CNT_W'(1));
  assign last_pix = (rd_idx_r == raw_dec[RAW_AW-1:0]);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    rem_nxt       = rem_r;
    raw_count_nxt = raw_count_r;
    rd_idx_nxt    = rd_idx_r;
    pop           = 1'b0;
    wr_en         = 1'b0;
    emit          = 1'b0;
    em_word       = cmd_r.value;
    em_hdr        = 1'b0;
    em_final      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          cmd_nxt = q_cmd;
          rem_nxt = q_cmd.cnt[TAIL_W-1:0];
          unique case (q_cmd.op)
            OP_PASS: state_nxt = S_PASS;
            OP_RUN:  state_nxt = S_RUN_HDR;
            OP_RAW: begin
              if (q_cmd.cnt[TAIL_W-1:0] != '0) begin
                state_nxt = S_PUSH;
              end else if (q_cmd.flush && raw_count_r != '0) begin
                state_nxt = S_FL_HDR;
              end else begin
                state_nxt = S_IDLE;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_PASS: begin
        if (free) begin
          emit      = 1'b1;
          em_final  = cmd_r.last;
          state_nxt = S_IDLE;
        end
      end
      S_RUN_HDR: begin
        if (free) begin
          emit      = 1'b1;
          em_word   = PIXEL_W'(run_hdr);
          em_hdr    = 1'b1;
          state_nxt = S_RUN_PIX;
        end
      end
      S_RUN_PIX: begin
        if (free) begin
          emit      = 1'b1;
          em_final  = cmd_r.last;
          state_nxt = S_IDLE;
        end
      end
      S_PUSH: begin
        // One copy per cycle; a full store flushes before the next copy.
        wr_en         = 1'b1;
        raw_count_nxt = raw_inc;
        rem_nxt       = rem_r - TAIL_W'(1);
        if (raw_inc == RAW_CNT_W'(RAW_CAP)) begin
          state_nxt = S_FL_HDR;
        end else if (rem_r == TAIL_W'(1)) begin
          state_nxt = cmd_r.flush ? S_FL_HDR : S_IDLE;
        end
      end
      S_FL_HDR: begin
        if (free) begin
          emit      = 1'b1;
          em_word   = PIXEL_W'(raw_dec);
          em_hdr    = 1'b1;
          state_nxt = S_FL_PIX;
        end
      end
      S_FL_PIX: begin
        if (free) begin
          emit     = 1'b1;
          em_word  = rd_data;
          // The request's last word unless copies remain that end in another flush.
          em_final = last_pix && cmd_r.last && ((rem_r == '0) || !cmd_r.flush);
          if (last_pix) begin
            raw_count_nxt = '0;
            rd_idx_nxt    = '0;
            state_nxt     = (rem_r != '0) ? S_PUSH : S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + RAW_AW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (clear) begin
      raw_count_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_word_nxt  = out_word_r;
    out_hdr_nxt   = out_hdr_r;
    out_last_nxt  = out_last_r;
    out_end_nxt   = out_end_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = em_word;
      out_hdr_nxt   = em_hdr;
      out_last_nxt  = em_final;
      out_end_nxt   = em_final && cmd_r.img_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rem_r       <= '0;
      raw_count_r <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rem_r       <= rem_nxt;
      raw_count_r <= raw_count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    out_word_r <= out_word_nxt;
    out_hdr_r  <= out_hdr_nxt;
    out_last_r <= out_last_nxt;
    out_end_r  <= out_end_nxt;
  end

  tga_rle_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (RAW_CAP)
  ) u_raw_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (raw_count_r[RAW_AW-1:0]),
    .wr_data (cmd_r.value),
    .rd_addr (rd_idx_nxt),
    .rd_data (rd_data)
  );

  assign out_chan.valid      = out_valid_r;
  assign out_chan.out_word   = out_word_r;
  assign out_chan.is_header  = out_hdr_r;
  assign out_chan.burst_last = out_last_r;
  assign out_chan.stream_end = out_end_r;

endmodule

FILE: rtl/tga_rle_pixel_encoder_unit.sv
// Top level of the Targa run-length pixel encoder for 32-bit pixels.
// Depends on tga_rle_pkg, the channel interfaces, tga_rle_front,
// tga_rle_cmd_fifo and tga_rle_back.
//
//   Channel  Direction  Handshake      Request carries
//   in_chan  input      valid/ready    pixel_value, image_end
//   out_chan output     valid/ready    out_word, is_header, burst_last, stream_end
//   cfg_*    input      write enable   compress_enable (cfg_wdata)
//
// Flow: the front takes a pixel per cycle while the queue has room and no second command
// from the previous pixel waits. The emitter pops a command while idle, then sends each
// pass-through pixel on as a word and a run packet as its header then its pixel, copies
// pixels into the raw store, and flushes a raw packet through the registered read port.
// Reset: synchronous, active low; only store entries below the fill count are read,
// so no clearing pass is needed. Either side stalls on its own across the queue.
module tga_rle_pixel_encoder_unit (
  input  logic           clk,
  input  logic           rst_n,
  tga_rle_pix_if.sink    in_chan,
  tga_rle_word_if.source out_chan,
  input  logic           cfg_we,
  input  logic           cfg_wdata
);
  import tga_rle_pkg::*;

  // Commands travel from the classifier to the emitter through a short queue,
  // so a stalled output does not immediately stop pixel intake.
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  cmd_t pop_cmd;
  logic q_empty;

  // The classifier holds the run tracking and the compression enable register.
  // A configuration write also clears any partial packet state.
  tga_rle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  tga_rle_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // The emitter owns the raw pixel store and its fill count, which a
  // configuration write resets as well.
  tga_rle_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (cfg_we),
    .q_empty  (q_empty),
    .q_cmd    (pop_cmd),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

FILE: rtl/tga_rle_checker.sv
// Port-level checks of the TGA RLE pixel encoder, attached by a bind statement.
// Depends on tga_rle_pkg and tga_rle_pixel_encoder_unit_defines.svh.
`include "tga_rle_pixel_encoder_unit_defines.svh"

module tga_rle_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [tga_rle_pkg::PIXEL_W-1:0] out_word,
  input logic                             is_header,
  input logic                             burst_last,
  input logic                             stream_end
);
  import tga_rle_pkg::*;

  // A header only ever carries the 8-bit packet byte.
  `TGA_RLE_ASSERT_NOW(a_hdr_upper_zero, out_valid && is_header, out_word[PIXEL_W-1:HDR_W] == '0, "header word has upper bits set")

  // Every header is followed by at least one pixel of the same request.
  `TGA_RLE_ASSERT_NOW(a_hdr_not_last, out_valid && is_header, !burst_last, "header word marked as last result")

  // The image end always closes the burst of its pixel.
  `TGA_RLE_ASSERT_NOW(a_end_is_last, out_valid && stream_end, burst_last, "stream end without burst end")

  `TGA_RLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word) && $stable(is_header), "stalled result changed")

endmodule

bind tga_rle_pixel_encoder_unit tga_rle_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_word   (out_chan.out_word),
  .is_header  (out_chan.is_header),
  .burst_last (out_chan.burst_last),
  .stream_end (out_chan.stream_end)
);

FILE: tb/tga_rle_pixel_encoder_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for tga_rle_pixel_encoder_unit: Targa run-length packets and pass-through.
// Needs tga_rle_pkg, the channel interfaces in tga_rle_if.sv and the encoder RTL.
module tga_rle_pixel_encoder_unit_test;
  import tga_rle_pkg::*;

  localparam int CLK_PERIOD_NS  = 10;
  localparam int RESET_CYCLES   = 5;
  // Cycles allowed after the last expected word before the block counts as idle.
  // Pixels that only land in the raw store cause no word, so the command queue
  // may still be busy while the emitter copies them when the output goes quiet.
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int TIMEOUT_CYCLES = 500000;
  localparam int STALL_PERCENT  = 30;

  // Packet rules of the encoder, derived from the packet size limit.
  localparam int RAW_HOLD_MAX   = 58;
  localparam int RAW_PACKET_MAX = (MAX_PACKET < RAW_HOLD_MAX) ? MAX_PACKET : RAW_HOLD_MAX;
  localparam int RUN_PACKET_MAX = (MAX_PACKET > 127) ? 127 : MAX_PACKET;
  localparam int MIN_RUN_LEN    = 4;
  localparam int BURST_MAX      = 63;
  localparam logic [7:0] RUN_HEADER_FLAG = 8'h80;

  typedef enum {
    SHAPE_MIXED,
    SHAPE_LONG_RUN,
    SHAPE_DISTINCT
  } image_shape_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               last;
  } pixel_req_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] word;
    logic               is_header;
    logic               burst_last;
    logic               stream_end;
  } packet_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  tga_rle_pix_if  pix_chan ();
  tga_rle_word_if word_chan ();

  tga_rle_pixel_encoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (pix_chan),
    .out_chan  (word_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Pixel requests waiting to be offered, and the packet words the encoder
  // is expected to produce, oldest first.
  pixel_req_t   pixel_requests [$];
  packet_word_t expected_words [$];
  packet_word_t burst_words [$];

  int unsigned error_count;
  bit          send_gaps;
  bit          recv_gaps;
  bit          hold_armed;
  logic        hold_active;

  // Shadow copy of the encoder state.
  bit                 compress_on;
  logic [PIXEL_W-1:0] raw_pixels [RAW_HOLD_MAX];
  logic [6:0]         raw_fill;
  logic [PIXEL_W-1:0] group_value;
  logic [6:0]         group_len;
  bit                 group_is_run;

  initial begin : clock_gen
    clk = 1'b0;
    forever #(CLK_PERIOD_NS / 2) clk = ~clk;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD_NS);
    $display("tga_rle_pixel_encoder_unit regression: fail");
    $finish;
  end

  task automatic report_mismatch(string what);
    $display("ERROR at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Encoder prediction. Every accepted pixel request runs through
  // encode_pixel, which appends the words that pixel causes to expected_words.
  // ---------------------------------------------------------------------------
  function automatic void put_packet_word(logic [PIXEL_W-1:0] word, logic hdr);
    packet_word_t w;
    if (burst_words.size() >= BURST_MAX) return;
    w = '{word, hdr, 1'b0, 1'b0};
    burst_words.push_back(w);
  endfunction

  // Raw packet: header count-1, then the held pixels in order.
  function automatic void flush_raw_packet();
    if (raw_fill == 0) return;
    put_packet_word(PIXEL_W'(8'(raw_fill - 7'd1)), 1'b1);
    for (int i = 0; i < raw_fill; i++) put_packet_word(raw_pixels[i], 1'b0);
    raw_fill = '0;
  endfunction

  // A full raw packet leaves at once, without waiting for a run or the image end.
  function automatic void hold_raw_pixel(logic [PIXEL_W-1:0] px);
    if (raw_fill < RAW_HOLD_MAX) begin
      raw_pixels[raw_fill] = px;
      raw_fill++;
    end
    if (raw_fill >= RAW_PACKET_MAX) flush_raw_packet();
  endfunction

  // A group of fewer than four equal pixels is not a run; it joins the raw packet.
  function automatic void group_to_raw();
    for (int i = 0; i < group_len; i++) hold_raw_pixel(group_value);
    group_len = '0;
  endfunction

  // Run packet: header (count-1) with the run flag, then the pixel once.
  function automatic void close_run();
    put_packet_word(PIXEL_W'(8'(group_len - 7'd1) | RUN_HEADER_FLAG), 1'b1);
    put_packet_word(group_value, 1'b0);
    group_len = '0;
    group_is_run = 1'b0;
  endfunction

  function automatic void clear_encoder();
    raw_fill = '0;
    group_value = '0;
    group_len = '0;
    group_is_run = 1'b0;
  endfunction

  function automatic void encode_pixel(logic [PIXEL_W-1:0] px, logic last_px);
    packet_word_t tail;
    burst_words.delete();
    if (!compress_on) begin
      put_packet_word(px, 1'b0);
    end else begin
      if (group_is_run) begin
        // A full run closes even when the next pixel is equal to it.
        if (px == group_value && group_len < RUN_PACKET_MAX) begin
          group_len++;
        end else begin
          close_run();
          group_value = px;
          group_len = 7'd1;
        end
      end else if (group_len > 0 && px == group_value) begin
        group_len++;
        if (group_len >= MIN_RUN_LEN) begin
          flush_raw_packet();
          group_is_run = 1'b1;
        end
      end else begin
        group_to_raw();
        group_value = px;
        group_len = 7'd1;
      end
      // The image end flushes everything, and a run never reaches past it.
      if (last_px) begin
        if (group_is_run) begin
          close_run();
        end else begin
          group_to_raw();
          flush_raw_packet();
        end
        clear_encoder();
      end
    end
    if (burst_words.size() > 0) begin
      tail = burst_words.pop_back();
      tail.burst_last = 1'b1;
      tail.stream_end = last_px;
      burst_words.push_back(tail);
    end
    foreach (burst_words[i]) expected_words.push_back(burst_words[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel driver. A request stays on the channel until the encoder takes it;
  // a new one is offered, or the channel idles at random, only after that.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : pixel_driver
    pixel_req_t req;
    if (!rst_n) begin
      pix_chan.valid <= 1'b0;
      pix_chan.pixel_value <= '0;
      pix_chan.image_end <= 1'b0;
    end else begin
      if (pix_chan.valid && pix_chan.ready) begin
        encode_pixel(pix_chan.pixel_value, pix_chan.image_end);
      end
      if (!pix_chan.valid || pix_chan.ready) begin
        if (pixel_requests.size() > 0 &&
            (!send_gaps || $urandom_range(99) >= STALL_PERCENT)) begin
          req = pixel_requests.pop_front();
          pix_chan.valid <= 1'b1;
          pix_chan.pixel_value <= req.pixel;
          pix_chan.image_end <= req.last;
        end else begin
          pix_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Word monitor. Each accepted word is checked against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : word_monitor
    packet_word_t got;
    packet_word_t want;
    if (!rst_n) begin
      word_chan.ready <= 1'b0;
    end else begin
      if (word_chan.valid && word_chan.ready) begin
        got = '{word_chan.out_word, word_chan.is_header, word_chan.burst_last,
                word_chan.stream_end};
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h hdr %b last %b end %b",
                                    got.word, got.is_header, got.burst_last,
                                    got.stream_end));
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf(
              "word %h hdr %b last %b end %b, expected %h hdr %b last %b end %b",
              got.word, got.is_header, got.burst_last, got.stream_end,
              want.word, want.is_header, want.burst_last, want.stream_end));
          end
        end
      end
      word_chan.ready <= !hold_active &&
                         (!recv_gaps || $urandom_range(99) >= STALL_PERCENT);
    end
  end

  // Long receiver hold-off: once armed, the output is blocked while hold_active
  // is high, so the encoder fills up and pushes back on its input.
  initial begin : receiver_hold
    hold_active = 1'b0;
    wait (hold_armed);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Pixels are queued and waits run at the falling edge, and the
  // configuration write uses nonblocking assignments, so none races the clocked driver and monitor.
  // ---------------------------------------------------------------------------
  task automatic push_pixel(logic [PIXEL_W-1:0] px, logic last_px);
    pixel_requests.push_back('{px, last_px});
  endtask

  // One image. Mixed images join short groups of palette colors and fresh
  // values, so groups of equal pixels can merge into runs; a long
  // run crosses the run cap; distinct pixels reach the raw cap and end in a
  // short group, so the image end can flush two raw packets at once.
  task automatic queue_image(image_shape_t shape, int pixels, bit closed);
    logic [PIXEL_W-1:0] palette [4];
    logic [PIXEL_W-1:0] value;
    int seg;
    for (int k = 0; k < 4; k++) palette[k] = $urandom;
    value = '0;
    seg = 0;
    for (int i = 0; i < pixels; i++) begin
      if (seg == 0) begin
        case (shape)
          SHAPE_LONG_RUN: begin
            value = $urandom;
            seg = pixels;
          end
          SHAPE_DISTINCT: begin
            value = $urandom;
            seg = (i >= pixels - 3) ? 3 : 1;
          end
          default: begin
            value = $urandom_range(1) ? palette[$urandom_range(3)] : $urandom;
            seg = $urandom_range(1) ? 1 : $urandom_range(2, 6);
          end
        endcase
      end
      push_pixel(value, closed && i == pixels - 1);
      seg--;
    end
  endtask

  // Waits until every request has been taken and every word has arrived,
  // then lets the encoder finish any work that causes no word.
  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_requests.size() != 0 || pix_chan.valid || expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The write drops any unfinished packet, in the encoder and in the shadow.
  task automatic write_compress(bit enable);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= enable;
    @(posedge clk);
    cfg_we <= 1'b0;
    compress_on = enable;
    clear_encoder();
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    pix_chan.valid = 1'b0;
    pix_chan.pixel_value = '0;
    pix_chan.image_end = 1'b0;
    word_chan.ready = 1'b0;
    error_count = 0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    hold_armed = 1'b0;
    compress_on = 1'b1;
    clear_encoder();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed images with compression on, as left by reset.
    // Exactly four equal pixels: the shortest run, ending with the image.
    repeat (3) push_pixel(32'hFFFF_FFFF, 1'b0);
    push_pixel(32'hFFFF_FFFF, 1'b1);
    // Distinct pixels only: one raw packet, field extremes.
    push_pixel(32'h0000_0000, 1'b0);
    push_pixel(32'hFFFF_FFFF, 1'b0);
    push_pixel(32'h0000_0000, 1'b1);
    // A one-pixel image.
    push_pixel(32'h5A5A_A5A5, 1'b1);
    // Three equal pixels at the image end stay raw.
    repeat (2) push_pixel(32'h0000_0007, 1'b0);
    push_pixel(32'h0000_0007, 1'b1);
    // Raw pixel, then a run, then a different pixel at the image end.
    push_pixel(32'h0000_0001, 1'b0);
    repeat (4) push_pixel(32'h0000_0002, 1'b0);
    push_pixel(32'h0000_0003, 1'b1);
    // A run broken by a different last pixel.
    repeat (4) push_pixel(32'hA5A5_5A5A, 1'b0);
    push_pixel(32'h8000_0001, 1'b1);
    wait_idle();

    // Pass-through: each pixel comes back as it is.
    write_compress(1'b0);
    @(negedge clk);
    push_pixel(32'h0000_0000, 1'b0);
    push_pixel(32'hFFFF_FFFF, 1'b1);
    repeat (6) push_pixel($urandom, $urandom_range(3) == 0);
    wait_idle();

    // Compression again: the caps, then mixed images, the last one left open.
    write_compress(1'b1);
    @(negedge clk);
    queue_image(SHAPE_LONG_RUN, $urandom_range(RUN_PACKET_MAX + 1, RUN_PACKET_MAX + 3), 1'b1);
    queue_image(SHAPE_DISTINCT, $urandom_range(RAW_PACKET_MAX, RAW_PACKET_MAX + 3), 1'b1);
    queue_image(SHAPE_MIXED, $urandom_range(3, 8), 1'b1);
    queue_image(SHAPE_MIXED, $urandom_range(3, 7), 1'b0);
    wait_idle();

    // Rewriting the same mode throws away the open image. Then the receiver
    // holds off while the sender keeps offering, with no random idling.
    write_compress(1'b1);
    @(negedge clk);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    hold_armed = 1'b1;
    repeat (2) queue_image(SHAPE_MIXED, $urandom_range(5, 8), 1'b1);
    wait_idle();

    write_compress(1'b0);
    @(negedge clk);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    repeat (6) push_pixel($urandom, $urandom_range(1));
    wait_idle();

    write_compress(1'b1);
    @(negedge clk);
    queue_image(SHAPE_MIXED, $urandom_range(3, 6), 1'b1);
    wait_idle();

    if (error_count == 0) begin
      $display("tga_rle_pixel_encoder_unit regression: pass");
    end else begin
      $display("tga_rle_pixel_encoder_unit regression: fail");
    end
    $finish;
  end

endmodule
